>>> rtl/shpc_pkg.sv
// Shared types, constants and scaling constants for the stepper homing controller.
package shpc_pkg;

   // Motor geometry
   localparam int STEPS_PER_REVOLUTION = 6400;
   localparam int POS_W                = 32;
   localparam int STEP_W               = $clog2(STEPS_PER_REVOLUTION + 1);

   // Byte scaling: (code * scale + ROUND_BIAS) / BYTE_MAX
   localparam int BYTE_MAX   = 255;
   localparam int ROUND_BIAS = 127;
   localparam int NORM_SCALE = 1000;
   localparam int NORM_W     = $clog2(NORM_SCALE + 1);

   // Division by BYTE_MAX done as a multiply by a rounded-up reciprocal.
   // A shift of numerator width + 8 keeps the quotient exact over the whole range.
   localparam int STEP_NUM_W  = $clog2(BYTE_MAX * STEPS_PER_REVOLUTION + ROUND_BIAS + 1);
   localparam int STEP_SHIFT  = STEP_NUM_W + 8;
   localparam int STEP_PROD_W = STEP_NUM_W + STEP_SHIFT - 7;
   localparam longint unsigned STEP_RECIP =
      ((longint'(1) << STEP_SHIFT) + longint'(BYTE_MAX - 1)) / longint'(BYTE_MAX);
   localparam longint unsigned STEP_K = STEP_RECIP * longint'(STEPS_PER_REVOLUTION);
   localparam longint unsigned STEP_C = STEP_RECIP * longint'(ROUND_BIAS);

   localparam int NORM_NUM_W  = $clog2(BYTE_MAX * NORM_SCALE + ROUND_BIAS + 1);
   localparam int NORM_SHIFT  = NORM_NUM_W + 8;
   localparam int NORM_PROD_W = NORM_NUM_W + NORM_SHIFT - 7;
   localparam longint unsigned NORM_RECIP =
      ((longint'(1) << NORM_SHIFT) + longint'(BYTE_MAX - 1)) / longint'(BYTE_MAX);
   localparam longint unsigned NORM_K = NORM_RECIP * longint'(NORM_SCALE);
   localparam longint unsigned NORM_C = NORM_RECIP * longint'(ROUND_BIAS);

   // Control byte threshold for a homing request
   localparam logic [7:0] HOME_REQ_MIN = 8'd128;

   // Rates
   localparam int SPEED_W = 18;
   localparam int ACCEL_W = 20;
   localparam logic [SPEED_W-1:0] HOME_SEEK_SPEED = SPEED_W'(2000);
   localparam logic [ACCEL_W-1:0] HOME_SEEK_ACCEL = ACCEL_W'(8000);
   localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(19200);
   localparam logic [SPEED_W-1:0] SPEED_MIN   = SPEED_W'(100);
   localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(200000);
   localparam logic [ACCEL_W-1:0] ACCEL_RESET = ACCEL_W'(64000);
   localparam logic [ACCEL_W-1:0] ACCEL_MIN   = ACCEL_W'(10);
   localparam logic [ACCEL_W-1:0] ACCEL_MAX   = ACCEL_W'(1000000);

   // Register map
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = ACCEL_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_SPEED = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_ACCEL = 1'b1;

   // Packed channel widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 160;

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_POSITION = 2'd1,
      MODE_HOMING   = 2'd2
   } motion_mode_type;

   typedef enum logic [1:0] {
      CMD_NONE     = 2'd0,
      CMD_STOP     = 2'd1,
      CMD_HOME_RUN = 2'd2,
      CMD_MOVE     = 2'd3
   } motion_cmd_type;

   typedef enum logic [1:0] {
      EVT_NONE   = 2'd0,
      EVT_HOMED  = 2'd1,
      EVT_FAILED = 2'd2
   } event_type;

   typedef struct packed {
      logic [SPEED_W-1:0] run_speed;
      logic [ACCEL_W-1:0] run_accel;
   } cfg_type;

   // Input item after decode and scaling
   typedef struct packed {
      logic                    tick;
      logic                    home_req;
      logic                    sensor;
      logic signed [POS_W-1:0] cur_pos;
      logic [STEP_W-1:0]       steps;
      logic [NORM_W-1:0]       norm;
   } in_item_type;

   typedef struct packed {
      motion_cmd_type          cmd;
      logic signed [POS_W-1:0] stop_position;
      logic signed [POS_W-1:0] target_out;
      logic [SPEED_W-1:0]      speed;
      logic [ACCEL_W-1:0]      accel;
      logic signed [POS_W-1:0] position_out;
      logic                    homed;
      logic                    homing;
      event_type               evt;
      logic [7:0]              position_byte;
      logic [NORM_W-1:0]       normalized_angle;
   } rsp_item_type;

endpackage

>>> rtl/shpc_csr.sv
// Run speed and acceleration registers with range saturation on write.
module shpc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [shpc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [shpc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output shpc_pkg::cfg_type                 cfg
);

   logic [shpc_pkg::SPEED_W-1:0] speed_ff, speed_in, speed_sat;
   logic [shpc_pkg::ACCEL_W-1:0] accel_ff, accel_in, accel_sat;
   logic [shpc_pkg::SPEED_W-1:0] speed_raw;

   // Saturate written values
   assign speed_raw = csr_wdata[shpc_pkg::SPEED_W-1:0];

   always_comb begin
      if (speed_raw < shpc_pkg::SPEED_MIN) begin
         speed_sat = shpc_pkg::SPEED_MIN;
      end else if (speed_raw > shpc_pkg::SPEED_MAX) begin
         speed_sat = shpc_pkg::SPEED_MAX;
      end else begin
         speed_sat = speed_raw;
      end
      if (csr_wdata < shpc_pkg::ACCEL_MIN) begin
         accel_sat = shpc_pkg::ACCEL_MIN;
      end else if (csr_wdata > shpc_pkg::ACCEL_MAX) begin
         accel_sat = shpc_pkg::ACCEL_MAX;
      end else begin
         accel_sat = csr_wdata;
      end
   end

   // Write decode
   always_comb begin
      speed_in = speed_ff;
      accel_in = accel_ff;
      if (csr_we) begin
         case (csr_addr)
            shpc_pkg::CSR_RUN_SPEED: speed_in = speed_sat;
            shpc_pkg::CSR_RUN_ACCEL: accel_in = accel_sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= shpc_pkg::SPEED_RESET;
         accel_ff <= shpc_pkg::ACCEL_RESET;
      end else begin
         speed_ff <= speed_in;
         accel_ff <= accel_in;
      end
   end

   assign cfg.run_speed = speed_ff;
   assign cfg.run_accel = accel_ff;

endmodule

>>> rtl/shpc_in_stage.sv
// Input register: decodes the item and scales the angle byte to steps and to 0..1000.
module shpc_in_stage (
   input  logic                                clock,
   input  logic                                load,
   input  logic                                tick,
   input  logic [7:0]                          angle_code,
   input  logic [7:0]                          control_code,
   input  logic                                home_sensor,
   input  logic signed [shpc_pkg::POS_W-1:0]   current_position,
   output shpc_pkg::in_item_type               item
);

   shpc_pkg::in_item_type item_ff, item_in;
   logic [shpc_pkg::STEP_PROD_W-1:0] step_prod;
   logic [shpc_pkg::NORM_PROD_W-1:0] norm_prod;

   // (angle * scale + bias) * recip folded into one constant multiply
   assign step_prod = shpc_pkg::STEP_PROD_W'(angle_code)
                    * shpc_pkg::STEP_PROD_W'(shpc_pkg::STEP_K)
                    + shpc_pkg::STEP_PROD_W'(shpc_pkg::STEP_C);
   assign norm_prod = shpc_pkg::NORM_PROD_W'(angle_code)
                    * shpc_pkg::NORM_PROD_W'(shpc_pkg::NORM_K)
                    + shpc_pkg::NORM_PROD_W'(shpc_pkg::NORM_C);

   always_comb begin
      item_in.tick     = tick;
      item_in.home_req = (control_code >= shpc_pkg::HOME_REQ_MIN);
      item_in.sensor   = home_sensor;
      item_in.cur_pos  = current_position;
      item_in.steps    = shpc_pkg::STEP_W'(step_prod >> shpc_pkg::STEP_SHIFT);
      item_in.norm     = shpc_pkg::NORM_W'(norm_prod >> shpc_pkg::NORM_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

>>> rtl/shpc_core.sv
// Homing and positioning decision, controller state and the result register.
module shpc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  shpc_pkg::in_item_type  item,
   input  shpc_pkg::cfg_type      cfg,
   output shpc_pkg::rsp_item_type rsp
);

   shpc_pkg::motion_mode_type mode_ff, mode_in;
   logic signed [shpc_pkg::POS_W-1:0] target_ff, target_in;
   logic signed [shpc_pkg::POS_W-1:0] origin_ff, origin_in;
   logic homed_ff, homed_in;
   logic homing_ff, homing_in;
   logic [shpc_pkg::NORM_W-1:0] norm_ff, norm_in;
   shpc_pkg::rsp_item_type rsp_ff, rsp_in;

   logic signed [shpc_pkg::POS_W-1:0] steps_pos;
   logic signed [shpc_pkg::POS_W:0]   travel;
   logic signed [shpc_pkg::POS_W:0]   rev_limit;
   logic far_enough;
   logic homed_stop, start_home, start_move, abort_home;
   logic signed [shpc_pkg::POS_W-1:0] pos;

   assign steps_pos = shpc_pkg::POS_W'(item.steps);
   assign rev_limit = (shpc_pkg::POS_W + 1)'(shpc_pkg::STEPS_PER_REVOLUTION);

   // Travel since homing started, 33 bits so it cannot wrap
   assign travel = {item.cur_pos[shpc_pkg::POS_W-1], item.cur_pos}
                 - {origin_ff[shpc_pkg::POS_W-1], origin_ff};
   assign far_enough = (travel >= rev_limit) || (travel <= -rev_limit);

   // Decision
   always_comb begin
      homed_stop = 1'b0;
      start_home = 1'b0;
      start_move = 1'b0;
      abort_home = 1'b0;
      if (!item.tick) begin
         if (item.home_req) begin
            if (item.sensor) begin
               homed_stop = (mode_ff == shpc_pkg::MODE_HOMING) || !homed_ff;
            end else begin
               start_home = (mode_ff != shpc_pkg::MODE_HOMING);
            end
         end else begin
            start_move = (mode_ff != shpc_pkg::MODE_POSITION) || (steps_pos != target_ff);
         end
      end else if (mode_ff == shpc_pkg::MODE_HOMING) begin
         if (item.sensor) begin
            homed_stop = 1'b1;
         end else begin
            abort_home = far_enough;
         end
      end
   end

   // Next state
   always_comb begin
      mode_in   = mode_ff;
      target_in = target_ff;
      origin_in = origin_ff;
      homed_in  = homed_ff;
      homing_in = homing_ff;
      norm_in   = norm_ff;
      if (!item.tick) begin
         norm_in   = item.norm;
         homing_in = item.home_req && !item.sensor;
         if (item.home_req && item.sensor) begin
            homed_in = 1'b1;
         end
      end
      if (start_home) begin
         target_in = steps_pos;
         origin_in = item.cur_pos;
         mode_in   = shpc_pkg::MODE_HOMING;
      end
      if (start_move) begin
         target_in = steps_pos;
         mode_in   = shpc_pkg::MODE_POSITION;
      end
      if (abort_home) begin
         target_in = item.cur_pos;
         homing_in = 1'b0;
         mode_in   = shpc_pkg::MODE_IDLE;
      end
      if (homed_stop) begin
         target_in = '0;
         homed_in  = 1'b1;
         homing_in = 1'b0;
         mode_in   = shpc_pkg::MODE_IDLE;
      end
   end

   // Result fields
   assign pos = homed_stop ? '0 : item.cur_pos;

   always_comb begin
      rsp_in.cmd           = shpc_pkg::CMD_NONE;
      rsp_in.stop_position = '0;
      rsp_in.speed         = cfg.run_speed;
      rsp_in.accel         = cfg.run_accel;
      rsp_in.evt           = shpc_pkg::EVT_NONE;
      if (start_home) begin
         rsp_in.cmd   = shpc_pkg::CMD_HOME_RUN;
         rsp_in.speed = shpc_pkg::HOME_SEEK_SPEED;
         rsp_in.accel = shpc_pkg::HOME_SEEK_ACCEL;
      end
      if (start_move) begin
         rsp_in.cmd = shpc_pkg::CMD_MOVE;
      end
      if (abort_home) begin
         rsp_in.cmd           = shpc_pkg::CMD_STOP;
         rsp_in.stop_position = item.cur_pos;
         rsp_in.evt           = shpc_pkg::EVT_FAILED;
      end
      if (homed_stop) begin
         rsp_in.cmd = shpc_pkg::CMD_STOP;
         rsp_in.evt = shpc_pkg::EVT_HOMED;
      end
      rsp_in.target_out       = target_in;
      rsp_in.position_out     = pos;
      rsp_in.homed            = homed_in;
      rsp_in.homing           = homing_in;
      rsp_in.normalized_angle = norm_in;
      // clamp to 0..255
      if (pos[shpc_pkg::POS_W-1]) begin
         rsp_in.position_byte = '0;
      end else if (|pos[shpc_pkg::POS_W-2:8]) begin
         rsp_in.position_byte = 8'hFF;
      end else begin
         rsp_in.position_byte = pos[7:0];
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= shpc_pkg::MODE_IDLE;
         target_ff <= '0;
         origin_ff <= '0;
         homed_ff  <= 1'b0;
         homing_ff <= 1'b0;
         norm_ff   <= '0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         target_ff <= target_in;
         origin_ff <= origin_in;
         homed_ff  <= homed_in;
         homing_ff <= homing_in;
         norm_ff   <= norm_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> rtl/stepper_homing_position_controller.sv
// Top level of the stepper homing and position controller.
//
//   channel  direction  handshake             payload
//   req_     in         req_tvalid/req_tready  tdata: command fields, tuser: tick flag
//   rsp_     out        rsp_tvalid/rsp_tready  tdata: motion command and status
//   csr_     in         csr_we                 csr_addr, csr_wdata
//
// An item passes from acceptance through the input register (angle scaling multiply),
// then through the decision logic into the result register.
// One item per cycle is sustained while rsp_tready holds; the input register takes a
// new item while a result waits. A stalled rsp_ holds its result and stalls req_ once
// the input register is also full. Reset is synchronous and empties both registers.
module stepper_homing_position_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] angle_code, [15:8] control_code, [16] home_sensor,
   // [48:17] current_position, [55:49] zero
   input  logic [shpc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] tick flag
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] motion_cmd, [33:2] stop_position, [65:34] target_out,
   // [83:66] speed_out, [103:84] accel_out, [135:104] position_out,
   // [136] homed_flag, [137] homing_flag, [139:138] event_res,
   // [147:140] position_byte, [157:148] normalized_angle, [159:158] zero
   output logic [shpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [shpc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [shpc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic req_accept, advance;
   shpc_pkg::cfg_type      cfg;
   shpc_pkg::in_item_type  item;
   shpc_pkg::rsp_item_type rsp;

   // Flow control
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   shpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   shpc_in_stage u_in_stage (
      .clock            (clock),
      .load             (req_accept),
      .tick             (req_tuser),
      .angle_code       (req_tdata[7:0]),
      .control_code     (req_tdata[15:8]),
      .home_sensor      (req_tdata[16]),
      .current_position (req_tdata[48:17]),
      .item             (item)
   );

   shpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg),
      .rsp     (rsp)
   );

   // Output packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp.normalized_angle,
                        rsp.position_byte,
                        rsp.evt,
                        rsp.homing,
                        rsp.homed,
                        rsp.position_out,
                        rsp.accel,
                        rsp.speed,
                        rsp.target_out,
                        rsp.stop_position,
                        rsp.cmd};

endmodule

>>> sim/stepper_homing_position_controller_tb.sv
// Testbench for the stepper homing position controller: directed table and random motion sequences.
`timescale 1ns / 100ps

module stepper_homing_position_controller_tb;

   // Block geometry and rate limits as the controller sees them
   localparam int REV_STEPS       = 6400;
   localparam int HOME_RUN_SPEED  = 2000;
   localparam int HOME_RUN_ACCEL  = 8000;
   localparam int SPEED_LO        = 100;
   localparam int SPEED_HI        = 200000;
   localparam int ACCEL_LO        = 10;
   localparam int ACCEL_HI        = 1000000;
   localparam int NUM_SETTINGS    = 6;
   localparam int PHASE_ITEMS     = 221;
   localparam int DRAIN_CYCLES    = 4;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct {
      logic               tick;
      logic [7:0]         angle;
      logic [7:0]         control;
      logic               sensor;
      logic signed [31:0] pos;
   } motion_req_type;

   typedef struct {
      motion_req_type           req;
      logic                     has_exp;
      shpc_pkg::motion_cmd_type cmd;
      shpc_pkg::event_type      evt;
   } directed_row_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [shpc_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                              req_tuser  = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [shpc_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_we     = 1'b0;
   logic [shpc_pkg::CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [shpc_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   stepper_homing_position_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: controller registers and run settings
   shpc_pkg::motion_mode_type     pred_mode   = shpc_pkg::MODE_IDLE;
   logic signed [31:0]            pred_target = '0;
   logic signed [31:0]            pred_origin = '0;
   logic                          pred_homed  = 1'b0;
   logic                          pred_homing = 1'b0;
   logic [7:0]                    pred_angle  = '0;
   logic [shpc_pkg::SPEED_W-1:0]  pred_speed  = shpc_pkg::SPEED_W'(19200);
   logic [shpc_pkg::ACCEL_W-1:0]  pred_accel  = shpc_pkg::ACCEL_W'(64000);

   shpc_pkg::rsp_item_type motion_expect_q[$];
   motion_req_type         stim_q[$];
   directed_row_type       directed_rows[$];

   int mismatches     = 0;
   int results_seen   = 0;
   int items_sent     = 0;
   int moves_seen     = 0;
   int home_runs_seen = 0;
   int homed_seen     = 0;
   int aborts_seen    = 0;
   int burst_left     = 0;
   int cycle_count    = 0;
   int stall_style    = 0;
   logic [7:0] last_move_angle = '0;

   logic [shpc_pkg::CSR_DATA_W-1:0] speed_set [NUM_SETTINGS];
   logic [shpc_pkg::CSR_DATA_W-1:0] accel_set [NUM_SETTINGS];

   // Next decision of the controller for one item; updates predictor state
   function automatic shpc_pkg::rsp_item_type predict_motion(input motion_req_type rq);
      shpc_pkg::rsp_item_type    r;
      logic                      home_req;
      logic                      homed_stop;
      int                        steps;
      shpc_pkg::motion_mode_type prev_mode;
      logic                      prev_homed;
      longint                    travel;
      logic signed [31:0]        pos;

      r          = '0;
      r.cmd      = shpc_pkg::CMD_NONE;
      r.evt      = shpc_pkg::EVT_NONE;
      r.speed    = pred_speed;
      r.accel    = pred_accel;
      pos        = rq.pos;
      homed_stop = 1'b0;

      if (!rq.tick) begin
         home_req   = rq.control >= 8'd128;
         steps      = (int'(rq.angle) * REV_STEPS + 127) / 255;
         prev_mode  = pred_mode;
         prev_homed = pred_homed;
         pred_angle  = rq.angle;
         pred_homing = home_req && !rq.sensor;
         if (home_req && rq.sensor)
            pred_homed = 1'b1;
         if (home_req) begin
            if (rq.sensor) begin
               if (prev_mode == shpc_pkg::MODE_HOMING || !prev_homed)
                  homed_stop = 1'b1;
            end else if (prev_mode != shpc_pkg::MODE_HOMING) begin
               r.cmd       = shpc_pkg::CMD_HOME_RUN;
               r.speed     = shpc_pkg::SPEED_W'(HOME_RUN_SPEED);
               r.accel     = shpc_pkg::ACCEL_W'(HOME_RUN_ACCEL);
               pred_target = steps;
               pred_origin = rq.pos;
               pred_homing = 1'b1;
               pred_mode   = shpc_pkg::MODE_HOMING;
            end
         end else if (prev_mode != shpc_pkg::MODE_POSITION || steps != pred_target) begin
            r.cmd       = shpc_pkg::CMD_MOVE;
            pred_target = steps;
            pred_homing = 1'b0;
            pred_mode   = shpc_pkg::MODE_POSITION;
         end
      end else if (pred_mode == shpc_pkg::MODE_HOMING) begin
         if (rq.sensor) begin
            homed_stop = 1'b1;
         end else begin
            // travel from the start of the run, no 32-bit wrap
            travel = longint'(rq.pos) - longint'(pred_origin);
            if (travel < 0)
               travel = -travel;
            if (travel >= REV_STEPS) begin
               r.cmd           = shpc_pkg::CMD_STOP;
               r.stop_position = rq.pos;
               pred_target     = rq.pos;
               pred_homing     = 1'b0;
               pred_mode       = shpc_pkg::MODE_IDLE;
               r.evt           = shpc_pkg::EVT_FAILED;
            end
         end
      end

      if (homed_stop) begin
         r.cmd           = shpc_pkg::CMD_STOP;
         r.stop_position = '0;
         pred_target     = '0;
         pred_homed      = 1'b1;
         pred_homing     = 1'b0;
         pred_mode       = shpc_pkg::MODE_IDLE;
         r.evt           = shpc_pkg::EVT_HOMED;
         pos             = '0;
      end

      r.target_out       = pred_target;
      r.position_out     = pos;
      r.homed            = pred_homed;
      r.homing           = pred_homing;
      r.position_byte    = (pos < 0) ? 8'd0 : ((pos > 255) ? 8'd255 : pos[7:0]);
      r.normalized_angle = shpc_pkg::NORM_W'((int'(pred_angle) * 1000 + 127) / 255);
      return r;
   endfunction

   function automatic shpc_pkg::rsp_item_type unpack_rsp(
      input logic [shpc_pkg::RSP_DATA_W-1:0] d);
      shpc_pkg::rsp_item_type r;
      r.cmd              = shpc_pkg::motion_cmd_type'(d[1:0]);
      r.stop_position    = d[33:2];
      r.target_out       = d[65:34];
      r.speed            = d[83:66];
      r.accel            = d[103:84];
      r.position_out     = d[135:104];
      r.homed            = d[136];
      r.homing           = d[137];
      r.evt              = shpc_pkg::event_type'(d[139:138]);
      r.position_byte    = d[147:140];
      r.normalized_angle = d[157:148];
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_motion(input shpc_pkg::rsp_item_type want,
                               input shpc_pkg::rsp_item_type got);
      check_field("motion_cmd",       want.cmd,              got.cmd);
      check_field("stop_position",    want.stop_position,    got.stop_position);
      check_field("target_out",       want.target_out,       got.target_out);
      check_field("speed_out",        want.speed,            got.speed);
      check_field("accel_out",        want.accel,            got.accel);
      check_field("position_out",     want.position_out,     got.position_out);
      check_field("homed_flag",       want.homed,            got.homed);
      check_field("homing_flag",      want.homing,           got.homing);
      check_field("event_res",        want.evt,              got.evt);
      check_field("position_byte",    want.position_byte,    got.position_byte);
      check_field("normalized_angle", want.normalized_angle, got.normalized_angle);
   endtask

   function automatic motion_req_type mk_req(input logic tick, input logic [7:0] angle,
                                             input logic [7:0] control, input logic sensor,
                                             input logic signed [31:0] pos);
      motion_req_type rq;
      rq.tick    = tick;
      rq.angle   = angle;
      rq.control = control;
      rq.sensor  = sensor;
      rq.pos     = pos;
      return rq;
   endfunction

   function automatic directed_row_type mk_row(input motion_req_type rq,
                                               input logic has_exp,
                                               input shpc_pkg::motion_cmd_type cmd,
                                               input shpc_pkg::event_type evt);
      directed_row_type row;
      row.req     = rq;
      row.has_exp = has_exp;
      row.cmd     = cmd;
      row.evt     = evt;
      return row;
   endfunction

   // Mostly moderate positions, sometimes near either end of the range
   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(0, 7))
         0:       return $urandom;
         1:       return 32'h7FFF_FFFF - $urandom_range(0, 8000);
         2:       return 32'h8000_0000 + $urandom_range(0, 8000);
         default: return int'($urandom_range(0, 40000)) - 20000;
      endcase
   endfunction

   // Drive one item with random burst gaps; predict it once accepted
   task automatic send_request(input motion_req_type rq, input logic has_exp,
                               input shpc_pkg::motion_cmd_type cmd,
                               input shpc_pkg::event_type evt);
      shpc_pkg::rsp_item_type want;
      int                     gap_len;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= rq.tick;
      req_tdata  <= {7'd0, rq.pos, rq.sensor, rq.control, rq.angle};
      do @(posedge clock); while (req_tready !== 1'b1);
      want = predict_motion(rq);
      if (has_exp) begin
         want.cmd = cmd;
         want.evt = evt;
      end
      case (want.cmd)
         shpc_pkg::CMD_MOVE:     moves_seen++;
         shpc_pkg::CMD_HOME_RUN: home_runs_seen++;
         default: ;
      endcase
      if (want.evt == shpc_pkg::EVT_HOMED)  homed_seen++;
      if (want.evt == shpc_pkg::EVT_FAILED) aborts_seen++;
      items_sent++;
      motion_expect_q.push_back(want);
   endtask

   // Hold the sender until every expected item is back and the pipe is empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (motion_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [shpc_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [shpc_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      // written values saturate into range
      if (addr == shpc_pkg::CSR_RUN_SPEED) begin
         if (value[17:0] < SPEED_LO)      pred_speed = shpc_pkg::SPEED_W'(SPEED_LO);
         else if (value[17:0] > SPEED_HI) pred_speed = shpc_pkg::SPEED_W'(SPEED_HI);
         else                             pred_speed = value[17:0];
      end else begin
         if (value[19:0] < ACCEL_LO)      pred_accel = shpc_pkg::ACCEL_W'(ACCEL_LO);
         else if (value[19:0] > ACCEL_HI) pred_accel = shpc_pkg::ACCEL_W'(ACCEL_HI);
         else                             pred_accel = value[19:0];
      end
   endtask

   // One random sequence of items into stim_q
   task automatic build_motion_sequence();
      logic signed [31:0] base;
      int                 n;
      int                 off;
      logic [7:0]         angle;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            // homing run: request off home, ticks within a revolution, then possibly an ending
            base = rand_pos();
            stim_q.push_back(mk_req(1'b0, 8'($urandom), 8'($urandom_range(128, 255)), 1'b0,
                                    base));
            n = $urandom_range(0, 6);
            repeat (n) begin
               if ($urandom_range(0, 5) == 0)
                  stim_q.push_back(mk_req(1'b0, 8'($urandom), 8'($urandom_range(128, 255)),
                                          1'b0, rand_pos()));
               else
                  stim_q.push_back(mk_req(1'b1, 8'($urandom), 8'($urandom), 1'b0,
                                          base + (int'($urandom_range(0, 12798)) - 6399)));
            end
            case ($urandom_range(0, 4))
               0: stim_q.push_back(mk_req(1'b1, 8'($urandom), 8'($urandom), 1'b1,
                                          rand_pos()));
               1: stim_q.push_back(mk_req(1'b0, 8'($urandom), 8'($urandom_range(128, 255)),
                                          1'b1, rand_pos()));
               2: begin
                  off = REV_STEPS + int'($urandom_range(0, 3000));
                  if ($urandom_range(0, 1)) off = -off;
                  stim_q.push_back(mk_req(1'b1, 8'($urandom), 8'($urandom), 1'b0,
                                          base + off));
               end
               3: stim_q.push_back(mk_req(1'b0, 8'($urandom), 8'($urandom_range(0, 127)),
                                          1'($urandom), rand_pos()));
               default: ;
            endcase
         end
         4, 5, 6: begin
            // positioning moves, some repeating the last angle
            n = $urandom_range(1, 4);
            repeat (n) begin
               angle = ($urandom_range(0, 3) == 0) ? last_move_angle : 8'($urandom);
               last_move_angle = angle;
               stim_q.push_back(mk_req(1'b0, angle, 8'($urandom_range(0, 127)),
                                       1'($urandom), rand_pos()));
            end
         end
         7: stim_q.push_back(mk_req(1'b0, 8'($urandom), 8'($urandom_range(128, 255)), 1'b1,
                                    rand_pos()));
         default: stim_q.push_back(mk_req(1'($urandom), 8'($urandom), 8'($urandom),
                                          1'($urandom), $urandom));
      endcase
   endtask

   // Receiver readiness: a new style is drawn whenever cycle_count[6:0] is zero
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[6:0] == 7'd0)
         stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= (cycle_count[1:0] == 2'd0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[stepper_homing_position_controller] ERROR");
         $finish;
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      shpc_pkg::rsp_item_type got;
      shpc_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = unpack_rsp(rsp_tdata);
         results_seen++;
         if (motion_expect_q.size() == 0) begin
            $error("result item with nothing expected: motion_cmd %0d", got.cmd);
            mismatches++;
         end else begin
            want = motion_expect_q.pop_front();
            check_motion(want, got);
         end
      end
   end

   initial begin
      speed_set = '{20'd0, 20'hFFFFF, 20'd100, 20'd200000, 20'd0, 20'd19200};
      accel_set = '{20'd0, 20'hFFFFF, 20'd10, 20'd1000000, 20'd0, 20'd64000};
      speed_set[4] = shpc_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF));
      accel_set[4] = shpc_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF));

      // Directed rows: cmd and event typed in, other fields from the predictor
      directed_rows.push_back(mk_row(mk_req(1'b1, 8'd0, 8'd0, 1'b0, 32'sd0),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
                                     // tick after reset
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd0, 8'd0, 1'b0, 32'sd0),
                                     1'b1, shpc_pkg::CMD_MOVE, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd0, 8'd0, 1'b0, 32'sd0),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
                                     // same target again
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd255, 8'd127, 1'b1, 32'h7FFF_FFFF),
                                     1'b1, shpc_pkg::CMD_MOVE, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd1, 8'd0, 1'b0, 32'h8000_0000),
                                     1'b1, shpc_pkg::CMD_MOVE, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd128, 8'd128, 1'b0, 32'sd1000),
                                     1'b1, shpc_pkg::CMD_HOME_RUN, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd0, 8'd255, 1'b0, 32'sd1000),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
                                     // request while homing
      directed_rows.push_back(mk_row(mk_req(1'b1, 8'd0, 8'd0, 1'b0, 32'sd7399),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
                                     // just short of a rev
      directed_rows.push_back(mk_row(mk_req(1'b1, 8'd0, 8'd0, 1'b0, -32'sd5400),
                                     1'b1, shpc_pkg::CMD_STOP, shpc_pkg::EVT_FAILED));
                                     // exactly one rev back
      directed_rows.push_back(mk_row(mk_req(1'b1, 8'd0, 8'd0, 1'b1, 32'sd0),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
                                     // tick while idle
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd77, 8'd200, 1'b1, 32'sd555),
                                     1'b1, shpc_pkg::CMD_STOP, shpc_pkg::EVT_HOMED));
                                     // at home, not homed
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd10, 8'd128, 1'b1, 32'sd42),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
                                     // at home, already homed
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd200, 8'd128, 1'b0, 32'h8000_0000),
                                     1'b1, shpc_pkg::CMD_HOME_RUN, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b1, 8'd0, 8'd0, 1'b0, 32'h7FFF_FFFF),
                                     1'b1, shpc_pkg::CMD_STOP, shpc_pkg::EVT_FAILED));
                                     // full-range travel
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd255, 8'd129, 1'b0, 32'h7FFF_FFFF),
                                     1'b1, shpc_pkg::CMD_HOME_RUN, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b1, 8'd0, 8'd0, 1'b1, 32'sd123),
                                     1'b1, shpc_pkg::CMD_STOP, shpc_pkg::EVT_HOMED));
                                     // sensor on tick
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd60, 8'd128, 1'b0, -32'sd300),
                                     1'b1, shpc_pkg::CMD_HOME_RUN, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd60, 8'd128, 1'b1, 32'sd12),
                                     1'b1, shpc_pkg::CMD_STOP, shpc_pkg::EVT_HOMED));
                                     // request at home mid-run
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd30, 8'd250, 1'b0, 32'sd5),
                                     1'b1, shpc_pkg::CMD_HOME_RUN, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd64, 8'd0, 1'b0, 32'sd77),
                                     1'b1, shpc_pkg::CMD_MOVE, shpc_pkg::EVT_NONE));
                                     // move breaks homing
      directed_rows.push_back(mk_row(mk_req(1'b1, 8'd0, 8'd0, 1'b1, 32'sd9),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd64, 8'd0, 1'b1, 32'sd9),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd64, 8'd128, 1'b1, 32'sd300),
                                     1'b1, shpc_pkg::CMD_NONE, shpc_pkg::EVT_NONE));
      directed_rows.push_back(mk_row(mk_req(1'b0, 8'd0, 8'd0, 1'b0, 32'sd256),
                                     1'b1, shpc_pkg::CMD_MOVE, shpc_pkg::EVT_NONE));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].has_exp,
                      directed_rows[i].cmd, directed_rows[i].evt);

      // Random phases, each under its own speed and acceleration setting
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         wait_drained();
         write_reg(shpc_pkg::CSR_RUN_SPEED, speed_set[s]);
         write_reg(shpc_pkg::CSR_RUN_ACCEL, accel_set[s]);
         csr_we <= 1'b0;
         for (int sent = 0; sent < PHASE_ITEMS; ) begin
            build_motion_sequence();
            while (stim_q.size() != 0) begin
               send_request(stim_q.pop_front(), 1'b0, shpc_pkg::CMD_NONE,
                            shpc_pkg::EVT_NONE);
               sent++;
            end
         end
      end

      wait_drained();
      if (motion_expect_q.size() != 0) begin
         $error("%0d expected result items never arrived", motion_expect_q.size());
         mismatches++;
      end
      $display("Sent %0d items, checked %0d results: %0d moves, %0d homing runs,",
               items_sent, results_seen, moves_seen, home_runs_seen);
      $display("%0d homed stops, %0d aborted runs, under %0d speed/accel settings.",
               homed_seen, aborts_seen, NUM_SETTINGS + 1);
      if (mismatches == 0) begin
         $display("[stepper_homing_position_controller] OK");
      end else begin
         $display("[stepper_homing_position_controller] ERROR");
      end
      $finish;
   end

endmodule
